>>> design/rwmv_pkg.sv
// ----------------------------------------------------------------------------
// rwmv_pkg
// Shared types and sizes for the ring window mean/variance core.
// ----------------------------------------------------------------------------
package rwmv_pkg;

  // Ring geometry: DEPTH slots, at most DEPTH-1 samples held.
  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);

  // Field widths of one transaction.
  localparam int OP_W     = 2;
  localparam int SMP_W    = 16;
  localparam int IDX_W    = 4;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 4;
  localparam int MEAN_W   = 24;
  localparam int VAR_W    = 38;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 88;

  // Accumulator and divider sizes for a window of up to 15 samples.
  localparam int SUM_W    = 21;   // signed sum of samples
  localparam int SQ_W     = 34;   // sum of squares
  localparam int NQ_W     = 38;   // count * sum of squares
  localparam int SS_W     = 42;   // sum * sum, full signed product
  localparam int DIV_W    = 46;   // dividend bits, Q.8 scaled
  localparam int DCNT_W   = 6;
  localparam int FRAC_W   = 8;
  localparam int DSV_W    = 8;    // count * count

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_STATS = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

>>> design/ring_window_mean_variance_core.sv
// Throughput: one transaction at a time; stats time is set by the memory walk
// (one slot per cycle) and the bit-serial divider (46 steps, one quotient bit each).
// Reset: synchronous, active low; clears pointers, state and output valid.
// The sample memory is not cleared; only data from written slots is ever used.
// ----------------------------------------------------------------------------
// ring_window_mean_variance_core
// Ring store of signed samples with indexed reads and window mean/variance.
// ----------------------------------------------------------------------------
module ring_window_mean_variance_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rwmv_pkg::IN_DW-1:0]     in_tdata,   // [15:0] sample, [19:16] index
  input  logic [rwmv_pkg::OP_W-1:0]      in_tuser,   // [1:0] operation
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rwmv_pkg::OUT_DW-1:0]    out_tdata,  // [15:0] read_value, [19:16] held_count,
                                                     // [43:20] mean_q8, [81:44] variance_q8
  output logic [rwmv_pkg::STAT_W-1:0]    out_tuser   // [1:0] status
);

  localparam int AW = rwmv_pkg::ADDR_W;

  // --------------------------------------------------------------------------
  // Pointer helpers: advance with wrap, and add an offset modulo DEPTH.
  // --------------------------------------------------------------------------
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(rwmv_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(rwmv_pkg::DEPTH)) begin
      s = s - (AW+1)'(rwmv_pkg::DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Input field unpacking
  // --------------------------------------------------------------------------
  rwmv_pkg::op_t                      in_op;
  logic signed [rwmv_pkg::SMP_W-1:0]  in_sample;
  logic [rwmv_pkg::IDX_W-1:0]         in_index;

  assign in_op     = rwmv_pkg::op_t'(in_tuser);
  assign in_sample = in_tdata[15:0];
  assign in_index  = in_tdata[19:16];

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  rwmv_pkg::state_t                   state_r, state_nxt;
  logic [AW-1:0]                      oldest_r, oldest_nxt;
  logic [AW-1:0]                      next_r, next_nxt;

  // stats walk
  logic [AW-1:0]                      walk_ptr_r, walk_ptr_nxt;
  logic [AW-1:0]                      cnt_r, cnt_nxt;
  logic                               pend_r, pend_nxt;
  logic [AW-1:0]                      n_r, n_nxt;
  logic signed [rwmv_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [rwmv_pkg::SQ_W-1:0]          sq_r, sq_nxt;

  // products and divider
  logic [rwmv_pkg::NQ_W-1:0]          nq_r, nq_nxt;
  logic [rwmv_pkg::VAR_W-1:0]         ss_r, ss_nxt;
  logic                               neg_r, neg_nxt;
  logic [rwmv_pkg::DIV_W-1:0]         dv_r, dv_nxt;
  logic [rwmv_pkg::DIV_W-1:0]         dm_r, dm_nxt;
  logic [rwmv_pkg::DSV_W-1:0]         dsv_r, dsv_nxt;
  logic [rwmv_pkg::DSV_W-1:0]         rv_r, rv_nxt;
  logic [AW-1:0]                      rm_r, rm_nxt;
  logic [rwmv_pkg::DCNT_W-1:0]        dcnt_r, dcnt_nxt;

  // pending result of the current transaction
  rwmv_pkg::status_t                  res_status_r, res_status_nxt;
  logic [rwmv_pkg::SMP_W-1:0]         res_read_r, res_read_nxt;
  logic [rwmv_pkg::MEAN_W-1:0]        res_mean_r, res_mean_nxt;
  logic [rwmv_pkg::VAR_W-1:0]         res_var_r, res_var_nxt;

  // output register
  logic                               out_valid_r, out_valid_nxt;
  rwmv_pkg::status_t                  out_status_r;
  logic [rwmv_pkg::SMP_W-1:0]         out_read_r;
  logic [rwmv_pkg::CNT_W-1:0]         out_held_r;
  logic [rwmv_pkg::MEAN_W-1:0]        out_mean_r;
  logic [rwmv_pkg::VAR_W-1:0]         out_var_r;
  logic                               out_load;

  // sample memory, one write and one registered read port
  logic [rwmv_pkg::SMP_W-1:0]         store_mem [rwmv_pkg::DEPTH];
  logic signed [rwmv_pkg::SMP_W-1:0]  rd_data_r;
  logic [AW-1:0]                      rd_addr;
  logic                               mem_we;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic [AW:0]                        held_ext;
  logic [AW-1:0]                      held_w;
  logic signed [31:0]                 sqr_w;
  logic signed [rwmv_pkg::SS_W-1:0]   ss_w;
  logic [rwmv_pkg::SUM_W-1:0]         abs_w;
  logic [rwmv_pkg::DSV_W:0]           tv_w;
  logic [AW:0]                        tm_w;
  logic                               qv_w, qm_w;

  // Held count from the two pointers.
  always_comb begin
    if (next_r >= oldest_r) begin
      held_ext = {1'b0, next_r} - {1'b0, oldest_r};
    end else begin
      held_ext = {1'b0, next_r} + (AW+1)'(rwmv_pkg::DEPTH) - {1'b0, oldest_r};
    end
    held_w = held_ext[AW-1:0];
  end

  assign sqr_w = rd_data_r * rd_data_r;
  assign ss_w  = sum_r * sum_r;
  assign abs_w = sum_r[rwmv_pkg::SUM_W-1] ? rwmv_pkg::SUM_W'(-sum_r)
                                          : rwmv_pkg::SUM_W'(sum_r);

  // One restoring step for each of the two quotients.
  assign tv_w = {rv_r, dv_r[rwmv_pkg::DIV_W-1]};
  assign qv_w = (tv_w >= {1'b0, dsv_r});
  assign tm_w = {rm_r, dm_r[rwmv_pkg::DIV_W-1]};
  assign qm_w = (tm_w >= {1'b0, n_r});

  assign in_tready = (state_r == rwmv_pkg::ST_IDLE);
  assign out_load  = (state_r == rwmv_pkg::ST_DONE) && (!out_valid_r || out_tready);

  // --------------------------------------------------------------------------
  // Next state and datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    oldest_nxt     = oldest_r;
    next_nxt       = next_r;
    walk_ptr_nxt   = walk_ptr_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    n_nxt          = n_r;
    sum_nxt        = sum_r;
    sq_nxt         = sq_r;
    nq_nxt         = nq_r;
    ss_nxt         = ss_r;
    neg_nxt        = neg_r;
    dv_nxt         = dv_r;
    dm_nxt         = dm_r;
    dsv_nxt        = dsv_r;
    rv_nxt         = rv_r;
    rm_nxt         = rm_r;
    dcnt_nxt       = dcnt_r;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    res_mean_nxt   = res_mean_r;
    res_var_nxt    = res_var_r;
    rd_addr        = walk_ptr_r;
    mem_we         = 1'b0;

    case (state_r)
      rwmv_pkg::ST_IDLE: begin
        rd_addr = wrap_add(oldest_r, in_index);
        if (in_tvalid) begin
          res_status_nxt = rwmv_pkg::STS_OK;
          res_read_nxt   = '0;
          res_mean_nxt   = '0;
          res_var_nxt    = '0;
          state_nxt      = rwmv_pkg::ST_DONE;
          case (in_op)
            rwmv_pkg::OP_PUSH: begin
              // write at the next slot; drop the oldest when the ring fills
              mem_we   = 1'b1;
              next_nxt = wrap_inc(next_r);
              if (wrap_inc(next_r) == oldest_r) begin
                oldest_nxt = wrap_inc(oldest_r);
              end
            end
            rwmv_pkg::OP_READ: begin
              if (AW'(in_index) >= held_w) begin
                res_status_nxt = rwmv_pkg::STS_RANGE;
              end else begin
                state_nxt = rwmv_pkg::ST_READ;
              end
            end
            rwmv_pkg::OP_STATS: begin
              if (held_w == '0) begin
                res_status_nxt = rwmv_pkg::STS_EMPTY;
              end else begin
                n_nxt        = held_w;
                walk_ptr_nxt = oldest_r;
                cnt_nxt      = '0;
                pend_nxt     = 1'b0;
                sum_nxt      = '0;
                sq_nxt       = '0;
                state_nxt    = rwmv_pkg::ST_SUM;
              end
            end
            default: begin
              // unused code: report the count, change nothing
            end
          endcase
        end
      end

      rwmv_pkg::ST_READ: begin
        res_read_nxt = rd_data_r;
        state_nxt    = rwmv_pkg::ST_DONE;
      end

      rwmv_pkg::ST_SUM: begin
        // issue one slot per cycle, accumulate the word read the cycle before
        if (cnt_r != n_r) begin
          walk_ptr_nxt = wrap_inc(walk_ptr_r);
          cnt_nxt      = cnt_r + 1'b1;
          pend_nxt     = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          sum_nxt = sum_r + rwmv_pkg::SUM_W'(rd_data_r);
          sq_nxt  = sq_r + {2'b00, sqr_w};
        end
        if ((cnt_r == n_r) && !pend_r) begin
          state_nxt = rwmv_pkg::ST_MUL;
        end
      end

      rwmv_pkg::ST_MUL: begin
        nq_nxt    = rwmv_pkg::NQ_W'(n_r) * rwmv_pkg::NQ_W'(sq_r);
        ss_nxt    = ss_w[rwmv_pkg::VAR_W-1:0];
        neg_nxt   = sum_r[rwmv_pkg::SUM_W-1];
        dm_nxt    = {{(rwmv_pkg::DIV_W - rwmv_pkg::SUM_W - rwmv_pkg::FRAC_W){1'b0}},
                     abs_w, {rwmv_pkg::FRAC_W{1'b0}}};
        dsv_nxt   = rwmv_pkg::DSV_W'(n_r) * rwmv_pkg::DSV_W'(n_r);
        state_nxt = rwmv_pkg::ST_LOAD;
      end

      rwmv_pkg::ST_LOAD: begin
        dv_nxt    = {nq_r - ss_r, {rwmv_pkg::FRAC_W{1'b0}}};
        rv_nxt    = '0;
        rm_nxt    = '0;
        dcnt_nxt  = '0;
        state_nxt = rwmv_pkg::ST_DIV;
      end

      rwmv_pkg::ST_DIV: begin
        rv_nxt   = qv_w ? rwmv_pkg::DSV_W'(tv_w - {1'b0, dsv_r}) : tv_w[rwmv_pkg::DSV_W-1:0];
        rm_nxt   = qm_w ? AW'(tm_w - {1'b0, n_r}) : tm_w[AW-1:0];
        dv_nxt   = {dv_r[rwmv_pkg::DIV_W-2:0], qv_w};
        dm_nxt   = {dm_r[rwmv_pkg::DIV_W-2:0], qm_w};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == rwmv_pkg::DCNT_W'(rwmv_pkg::DIV_W - 1)) begin
          state_nxt = rwmv_pkg::ST_FIN;
        end
      end

      rwmv_pkg::ST_FIN: begin
        // restore the sign of the mean; truncation is toward zero
        res_mean_nxt = neg_r ? rwmv_pkg::MEAN_W'(-dm_r[rwmv_pkg::MEAN_W-1:0])
                             : dm_r[rwmv_pkg::MEAN_W-1:0];
        res_var_nxt  = dv_r[rwmv_pkg::VAR_W-1:0];
        state_nxt    = rwmv_pkg::ST_DONE;
      end

      rwmv_pkg::ST_DONE: begin
        // hold until the output register is free
        if (out_load) begin
          state_nxt = rwmv_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rwmv_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // State and control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwmv_pkg::ST_IDLE;
      oldest_r    <= '0;
      next_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    walk_ptr_r   <= walk_ptr_nxt;
    cnt_r        <= cnt_nxt;
    n_r          <= n_nxt;
    sum_r        <= sum_nxt;
    sq_r         <= sq_nxt;
    nq_r         <= nq_nxt;
    ss_r         <= ss_nxt;
    neg_r        <= neg_nxt;
    dv_r         <= dv_nxt;
    dm_r         <= dm_nxt;
    dsv_r        <= dsv_nxt;
    rv_r         <= rv_nxt;
    rm_r         <= rm_nxt;
    dcnt_r       <= dcnt_nxt;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    res_mean_r   <= res_mean_nxt;
    res_var_r    <= res_var_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_read_r   <= res_read_r;
      out_held_r   <= rwmv_pkg::CNT_W'(held_w);
      out_mean_r   <= res_mean_r;
      out_var_r    <= res_var_r;
    end
  end

  // Sample memory. A push may write the slot that the idle read addresses in the
  // same cycle; that read data is then never used, since only a read takes it.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[next_r] <= in_sample;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Output packing
  // --------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, out_var_r, out_mean_r, out_held_r, out_read_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_op == rwmv_pkg::OP_PUSH)) |=> (held_w != '0))
    else $error("ring empty after a push");

  a_nonpush_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_op != rwmv_pkg::OP_PUSH))
      |=> ($stable(oldest_r) && $stable(next_r)))
    else $error("pointers moved on a non-push transaction");

  a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rwmv_pkg::ST_SUM) |-> (n_r != '0))
    else $error("stats walk started on an empty ring");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rwmv_pkg::ST_DIV) |-> ((rv_r < dsv_r) && (rm_r < n_r)))
    else $error("divider remainder out of range");

  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_tvalid && (state_r == rwmv_pkg::ST_IDLE)))
    else $error("result not presented after completion");

endmodule
